/* sv/hvt_pkg.sv */
// Shared types, format constants and helpers for the homogeneous vertex transform.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hvt_pkg;

  // Number formats.
  localparam int COORD_W = 32;                  // signed coordinate, Q16.16
  localparam int COEF_W  = 16;                  // signed coefficient, Q8.8
  localparam int CFRAC   = COORD_W / 2;
  localparam int KFRAC   = COEF_W / 2;
  localparam int IW      = COORD_W - CFRAC;     // integer bits of a coordinate
  localparam int PROD_W  = COORD_W + COEF_W;
  localparam int ACC_W   = COORD_W + COEF_W + 2;
  localparam int QW      = IW + CFRAC + 1;      // quotient bits incl. one rounding bit
  localparam int ROW_W   = 4 * COEF_W;
  localparam int COL_W   = 3 * COEF_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;
  localparam logic [CFG_IDX_W-1:0] REG_FWD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FWD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV2 = 3'd6;

  // Opcodes.
  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_DIR    = 2'd1;
  localparam logic [1:0] OP_NORMAL = 2'd2;

  // Queue depth between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  // Decoded operation class; all zero for the unused opcode.
  typedef struct packed {
    logic pt;
    logic dir;
    logic nrm;
  } cls_t;

  typedef struct packed {
    cls_t   cls;
    coord_t x;
    coord_t y;
    coord_t z;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] fwd0;
    logic [ROW_W-1:0] fwd1;
    logic [ROW_W-1:0] fwd2;
    logic [ROW_W-1:0] fwd3;
    logic [COL_W-1:0] inv0;
    logic [COL_W-1:0] inv1;
    logic [COL_W-1:0] inv2;
  } mat_t;

  typedef struct packed {
    coord_t v;
    logic   sat;
  } clamp_t;

  // Clamp a sign and magnitude to the coordinate range.
  function automatic clamp_t clamp_mag(logic neg, logic [ACC_W-1:0] mag);
    clamp_t r;
    logic [ACC_W-1:0] lim;
    lim = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    r.sat = 1'b0;
    if (neg) begin
      if (mag > lim + ACC_W'(1)) begin
        r.v   = {1'b1, {(COORD_W-1){1'b0}}};
        r.sat = 1'b1;
      end else begin
        r.v = ~mag[COORD_W-1:0] + 1'b1;
      end
    end else begin
      if (mag > lim) begin
        r.v   = {1'b0, {(COORD_W-1){1'b1}}};
        r.sat = 1'b1;
      end else begin
        r.v = mag[COORD_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/homogeneous_vertex_transform.sv */
// Top level of the homogeneous vertex transform; instantiates the register file,
// front end, queue and arithmetic back end. Depends on hvt_pkg.
`default_nettype none

// Transforms one Q16.16 coordinate triple per cycle by a Q8.8 4x4 matrix: points
// use the full forward matrix and are divided by w unless w is exactly one or
// zero, directions use the upper 3x3, normals the transposed inverse 3x3. A new
// word is accepted every cycle as long as results are taken; the divide-by-w
// pipeline produces one quotient bit per stage. A four-word queue separates the
// input decode from the arithmetic pipeline. The user must write the matrix
// registers through the cfg port only while no word is in flight; the block
// itself does not enforce it.
module homogeneous_vertex_transform (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hvt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [1:0]                     in_opcode,
  input  wire hvt_pkg::coord_t                in_x,
  input  wire hvt_pkg::coord_t                in_y,
  input  wire hvt_pkg::coord_t                in_z,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      hvt_pkg::coord_t                out_x,
  output      hvt_pkg::coord_t                out_y,
  output      hvt_pkg::coord_t                out_z,
  output      logic                           out_w_zero,
  output      logic                           out_saturated
);
  import hvt_pkg::*;

  mat_t  mat;
  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  qb_valid, qb_ready;
  item_t qb_item;

  hvt_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  hvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  hvt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  hvt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mat           (mat),
    .s_valid       (qb_valid),
    .s_ready       (qb_ready),
    .s_item        (qb_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w_zero    (out_w_zero),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

/* sv/hvt_regs.sv */
// Matrix configuration registers of the vertex transform.
// Depends on hvt_pkg for the register indexes and the matrix struct.
`default_nettype none

module hvt_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hvt_pkg::CFG_DATA_W-1:0] cfg_data,
  output      hvt_pkg::mat_t                  mat
);
  import hvt_pkg::*;

  localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << KFRAC;

  mat_t mat_r;
  logic wr;

  // Writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign mat       = mat_r;

  // Register file, identity at reset; out-of-range indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r.fwd0 <= ONE;
      mat_r.fwd1 <= ONE << COEF_W;
      mat_r.fwd2 <= ONE << (2 * COEF_W);
      mat_r.fwd3 <= ONE << (3 * COEF_W);
      mat_r.inv0 <= ONE[COL_W-1:0];
      mat_r.inv1 <= ONE[COL_W-1:0] << COEF_W;
      mat_r.inv2 <= ONE[COL_W-1:0] << (2 * COEF_W);
    end else if (wr) begin
      case (cfg_index)
        REG_FWD0: mat_r.fwd0 <= cfg_data;
        REG_FWD1: mat_r.fwd1 <= cfg_data;
        REG_FWD2: mat_r.fwd2 <= cfg_data;
        REG_FWD3: mat_r.fwd3 <= cfg_data;
        REG_INV0: mat_r.inv0 <= cfg_data[COL_W-1:0];
        REG_INV1: mat_r.inv1 <= cfg_data[COL_W-1:0];
        REG_INV2: mat_r.inv2 <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/hvt_front.sv */
// Front end of the vertex transform: accepts input words and decodes the opcode.
// Depends on hvt_pkg for the opcode codes and the queued word type.
`default_nettype none

module hvt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire logic [1:0]      in_opcode,
  input  wire hvt_pkg::coord_t in_x,
  input  wire hvt_pkg::coord_t in_y,
  input  wire hvt_pkg::coord_t in_z,
  output      logic            q_valid,
  input  wire logic            q_ready,
  output      hvt_pkg::item_t  q_item
);
  import hvt_pkg::*;

  logic  v_r;
  item_t item_r;
  cls_t  cls;

  // The stage takes a new word whenever it is empty or its word moves on.
  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_item   = item_r;

  // Opcode decode; the unused code leaves every class bit clear.
  always_comb begin
    cls = '0;
    case (in_opcode)
      OP_POINT:  cls.pt  = 1'b1;
      OP_DIR:    cls.dir = 1'b1;
      OP_NORMAL: cls.nrm = 1'b1;
      default:   cls = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.cls <= cls;
      item_r.x   <= in_x;
      item_r.y   <= in_y;
      item_r.z   <= in_z;
    end
  end

endmodule

`default_nettype wire

/* sv/hvt_fifo.sv */
// Short queue between the front end and the arithmetic back end.
// Depends on hvt_pkg for the queued word type and the depth.
`default_nettype none

module hvt_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output      logic           wr_ready,
  input  wire hvt_pkg::item_t wr_item,
  output      logic           rd_valid,
  input  wire logic           rd_ready,
  output      hvt_pkg::item_t rd_item
);
  import hvt_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

  // The queue never holds more words than it has entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

/* sv/hvt_back.sv */
// Arithmetic back end: matrix product, rounding, pipelined divide by w, saturation.
// Depends on hvt_pkg for formats, the matrix struct and the clamp helper.
`default_nettype none

module hvt_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire hvt_pkg::mat_t   mat,
  input  wire logic            s_valid,
  output      logic            s_ready,
  input  wire hvt_pkg::item_t  s_item,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      hvt_pkg::coord_t out_x,
  output      hvt_pkg::coord_t out_y,
  output      hvt_pkg::coord_t out_z,
  output      logic            out_w_zero,
  output      logic            out_saturated
);
  import hvt_pkg::*;

  localparam logic [ACC_W-1:0] W_ONE = ACC_W'(1) << (CFRAC + KFRAC);
  localparam logic [ACC_W-1:0] RND   = ACC_W'(1) << (KFRAC - 1);

  // One divider lane: partial remainder, unused dividend bits, quotient so far.
  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [QW-1:0]    nlow;
    logic [QW-1:0]    q;
  } dlane_t;

  // Per-word side data carried alongside the divider.
  typedef struct packed {
    logic       div;
    logic [2:0] neg;
    logic [2:0] ovf;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic       wz;
    logic       sat;
  } side_t;

  logic adv;

  // Stage 1: products.
  logic                     v1_r;
  cls_t                     cls1_r;
  logic signed [PROD_W-1:0] p1_r [4][3];
  coef_t                    t1_r [4];

  // Stage 2: sums.
  logic                     v2_r;
  cls_t                     cls2_r;
  logic signed [ACC_W-1:0]  acc2_r [4];

  // Stage 3: magnitudes and mode.
  logic                     v3_r;
  cls_t                     cls3_r;
  logic                     wone3_r, wzero3_r;
  logic [ACC_W-1:0]         a3_r [3];
  logic [2:0]               n3_r;
  logic [ACC_W-1:0]         b3_r;
  logic                     nw3_r;

  // Divider pipeline; index 0 is the setup stage.
  logic                     dv_r [QW+1];
  dlane_t                   dl_r [QW+1][3];
  logic [ACC_W-1:0]         db_r [QW+1];
  side_t                    ds_r [QW+1];

  // Output register.
  logic                     vo_r;
  coord_t                   xo_r, yo_r, zo_r;
  logic                     wzo_r, sato_r;

  // The whole pipeline moves together whenever the output slot is free.
  assign adv     = !vo_r || out_ready;
  assign s_ready = adv;

  // Stage 1: select the coefficient rows and form all products.
  always_ff @(posedge clk) begin
    coord_t cj;
    if (adv) begin
      cls1_r <= s_item.cls;
      for (int j = 0; j < 3; j++) begin
        cj = (j == 0) ? s_item.x : ((j == 1) ? s_item.y : s_item.z);
        if (s_item.cls.nrm) begin
          p1_r[0][j] <= coef_t'(mat.inv0[j*COEF_W +: COEF_W]) * cj;
          p1_r[1][j] <= coef_t'(mat.inv1[j*COEF_W +: COEF_W]) * cj;
          p1_r[2][j] <= coef_t'(mat.inv2[j*COEF_W +: COEF_W]) * cj;
        end else begin
          p1_r[0][j] <= coef_t'(mat.fwd0[j*COEF_W +: COEF_W]) * cj;
          p1_r[1][j] <= coef_t'(mat.fwd1[j*COEF_W +: COEF_W]) * cj;
          p1_r[2][j] <= coef_t'(mat.fwd2[j*COEF_W +: COEF_W]) * cj;
        end
        p1_r[3][j] <= coef_t'(mat.fwd3[j*COEF_W +: COEF_W]) * cj;
      end
      // Translation only applies to points.
      t1_r[0] <= s_item.cls.pt ? coef_t'(mat.fwd0[3*COEF_W +: COEF_W]) : '0;
      t1_r[1] <= s_item.cls.pt ? coef_t'(mat.fwd1[3*COEF_W +: COEF_W]) : '0;
      t1_r[2] <= s_item.cls.pt ? coef_t'(mat.fwd2[3*COEF_W +: COEF_W]) : '0;
      t1_r[3] <= s_item.cls.pt ? coef_t'(mat.fwd3[3*COEF_W +: COEF_W]) : '0;
    end
  end

  // Stage 2: exact row sums with the translation aligned to the product scale.
  always_ff @(posedge clk) begin
    if (adv) begin
      cls2_r <= cls1_r;
      for (int i = 0; i < 4; i++) begin
        acc2_r[i] <= ACC_W'(p1_r[i][0]) + ACC_W'(p1_r[i][1]) + ACC_W'(p1_r[i][2])
                   + (ACC_W'(t1_r[i]) <<< CFRAC);
      end
    end
  end

  // Stage 3: magnitudes, signs and the w tests.
  always_ff @(posedge clk) begin
    if (adv) begin
      cls3_r   <= cls2_r;
      wone3_r  <= (acc2_r[3] == W_ONE);
      wzero3_r <= (acc2_r[3] == '0);
      for (int i = 0; i < 3; i++) begin
        a3_r[i] <= acc2_r[i][ACC_W-1] ? -acc2_r[i] : acc2_r[i];
        n3_r[i] <= acc2_r[i][ACC_W-1];
      end
      b3_r  <= acc2_r[3][ACC_W-1] ? -acc2_r[3] : acc2_r[3];
      nw3_r <= acc2_r[3][ACC_W-1];
    end
  end

  // Setup stage: round the undivided results and load the divider lanes.
  always_ff @(posedge clk) begin
    clamp_t cr [3];
    logic   divm, zerom;
    if (adv) begin
      divm  = cls3_r.pt && !wone3_r && !wzero3_r;
      zerom = (cls3_r == '0) || (cls3_r.pt && wzero3_r);
      for (int i = 0; i < 3; i++) begin
        cr[i] = clamp_mag(n3_r[i], (a3_r[i] + RND) >> KFRAC);
        ds_r[0].neg[i] <= n3_r[i] ^ nw3_r;
        ds_r[0].ovf[i] <= (a3_r[i] >> IW) >= b3_r;
        dl_r[0][i].rem <= ((a3_r[i] >> IW) >= b3_r) ? '0 : (a3_r[i] >> IW);
        dl_r[0][i].nlow <= {a3_r[i][IW-1:0], {(CFRAC+1){1'b0}}};
        dl_r[0][i].q <= '0;
      end
      db_r[0]     <= b3_r;
      ds_r[0].div <= divm;
      ds_r[0].wz  <= cls3_r.pt && wzero3_r;
      ds_r[0].x   <= zerom ? '0 : cr[0].v;
      ds_r[0].y   <= zerom ? '0 : cr[1].v;
      ds_r[0].z   <= zerom ? '0 : cr[2].v;
      ds_r[0].sat <= !zerom && (cr[0].sat || cr[1].sat || cr[2].sat);
    end
  end

  // Restoring divide, one quotient bit per stage and lane.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [ACC_W:0] trial;
      if (adv) begin
        db_r[k] <= db_r[k-1];
        ds_r[k] <= ds_r[k-1];
        for (int i = 0; i < 3; i++) begin
          trial = {dl_r[k-1][i].rem, dl_r[k-1][i].nlow[QW-1]};
          if (trial >= {1'b0, db_r[k-1]}) begin
            dl_r[k][i].rem <= ACC_W'(trial - {1'b0, db_r[k-1]});
            dl_r[k][i].q   <= {dl_r[k-1][i].q[QW-2:0], 1'b1};
          end else begin
            dl_r[k][i].rem <= trial[ACC_W-1:0];
            dl_r[k][i].q   <= {dl_r[k-1][i].q[QW-2:0], 1'b0};
          end
          dl_r[k][i].nlow <= dl_r[k-1][i].nlow << 1;
        end
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k <= QW; k++) dv_r[k] <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= s_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      dv_r[0] <= v3_r;
      for (int k = 1; k <= QW; k++) dv_r[k] <= dv_r[k-1];
      vo_r  <= dv_r[QW];
    end
  end

  // Output stage: round the quotient half away from zero, clamp, merge flags.
  always_ff @(posedge clk) begin
    clamp_t   dr [3];
    logic [QW:0] qr;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        qr = ({1'b0, dl_r[QW][i].q} + (QW+1)'(1)) >> 1;
        if (ds_r[QW].ovf[i]) begin
          dr[i] = clamp_mag(ds_r[QW].neg[i], ACC_W'(1) << COORD_W);
        end else begin
          dr[i] = clamp_mag(ds_r[QW].neg[i], ACC_W'(qr));
        end
      end
      wzo_r <= ds_r[QW].wz;
      if (ds_r[QW].div) begin
        xo_r   <= dr[0].v;
        yo_r   <= dr[1].v;
        zo_r   <= dr[2].v;
        sato_r <= dr[0].sat || dr[1].sat || dr[2].sat;
      end else begin
        xo_r   <= ds_r[QW].x;
        yo_r   <= ds_r[QW].y;
        zo_r   <= ds_r[QW].z;
        sato_r <= ds_r[QW].sat;
      end
    end
  end

  assign out_valid     = vo_r;
  assign out_x         = xo_r;
  assign out_y         = yo_r;
  assign out_z         = zo_r;
  assign out_w_zero    = wzo_r;
  assign out_saturated = sato_r;

  // A word in divide mode never has a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] && ds_r[0].div |-> db_r[0] != '0)
    else $error("divide with zero divisor");

  // The partial remainder stays below the divisor through the last step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[QW] && ds_r[QW].div |-> dl_r[QW][0].rem < db_r[QW])
    else $error("divider remainder out of range");

  // A zero-w result carries zero coordinates and no saturation.
  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> (out_x == '0) && (out_y == '0) && (out_z == '0)
                                && !out_saturated)
    else $error("zero w result not cleared");

endmodule

`default_nettype wire
